// ----- rtl/ctph_pkg.sv -----
// Shared types, constants and a helper function for the piecewise digest unit.
package ctph_pkg;

    localparam int ROLL_WINDOW_DEF = 7;
    localparam int DIGEST_LEN_DEF  = 64;
    localparam int BLOCK_SIZE_W    = 31;
    localparam int HASH_W          = 32;
    localparam int BYTE_W          = 8;
    localparam int CHAR_W          = 7;

    localparam logic [HASH_W-1:0]       PIECE_INIT     = 32'h2802_1967;
    localparam logic [HASH_W-1:0]       FNV_PRIME      = 32'h0100_0193;
    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 31'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_LOAD,
        S_DIV,
        S_EVAL,
        S_EMIT_ONE,
        S_EMIT_TWO,
        S_CLOSE_ONE,
        S_CLOSE_TWO
    } ctph_state_t;

    typedef enum logic [1:0] {
        EMIT_PIECE_ONE,
        EMIT_PIECE_TWO,
        EMIT_CLOSE_ONE,
        EMIT_CLOSE_TWO
    } ctph_emit_sel_t;

    typedef struct packed {
        logic           load;
        logic           update;
        logic           mod_start;
        logic           capture;
        logic           emit;
        ctph_emit_sel_t sel;
        logic           clear;
    } ctph_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic trig_one;
        logic trig_two;
        logic eom;
        logic out_free;
    } ctph_status_t;

    // Maps a six-bit value to the ASCII code of its base64 character.
    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
        logic [CHAR_W-1:0] ch;
        if (idx < 6'd26)
        begin
            ch = 7'd65 + {1'b0, idx};
        end
        else if (idx < 6'd52)
        begin
            ch = 7'd71 + {1'b0, idx};
        end
        else if (idx < 6'd62)
        begin
            ch = {1'b0, idx} - 7'd4;
        end
        else if (idx == 6'd62)
        begin
            ch = 7'd43;
        end
        else
        begin
            ch = 7'd47;
        end
        return ch;
    endfunction

endpackage

// ----- rtl/ctph_piecewise_digest_unit.sv -----
// Top level of the piecewise context-triggered digest unit.
// The input channel carries one message byte per word, with end_of_message set on
// the final byte; in_stall is high whenever the unit is busy with a byte.
// The output channel carries digest characters, one per word, at most four per
// byte: the digest one trigger character, the digest two trigger character, then
// on the final byte the two closing characters; last_of_item marks the final one.
// A byte that is not final and triggers nothing produces no output word.
// Each byte goes through load, hash update, the bit-serial remainder unit, which
// produces one quotient bit per cycle over the 32-bit rolling value, trigger
// capture and then emission, one word at a time; the next byte is accepted once
// the last word has been placed in the output register.
// When the receiver stalls, the pending word holds and emission pauses.
// The configuration channel writes block_size; it is ready only while no byte is
// in progress. Reset sets block_size to three and clears all message state; a
// final byte also clears the message state for the next message.
module ctph_piecewise_digest_unit #(
    parameter int ROLL_WINDOW = ctph_pkg::ROLL_WINDOW_DEF,
    parameter int DIGEST_LEN  = ctph_pkg::DIGEST_LEN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ctph_pkg::BLOCK_SIZE_W-1:0]  block_size,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ctph_pkg::BYTE_W-1:0]        data_byte,
    input  logic                               end_of_message,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ctph_pkg::CHAR_W-1:0]        digest_char,
    output logic                               which_digest,
    output logic                               is_closing,
    output logic                               last_of_item
);
    import ctph_pkg::*;

    ctph_cmd_t    cmd;
    ctph_status_t sts;
    logic         idle;

    ctph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    ctph_datapath #(
        .ROLL_WINDOW (ROLL_WINDOW),
        .DIGEST_LEN  (DIGEST_LEN)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_block_size (block_size),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_char    (digest_char),
        .which_digest   (which_digest),
        .is_closing     (is_closing),
        .last_of_item   (last_of_item)
    );

    assign in_stall  = !idle;
    assign cfg_ready = idle;

    // An accepted byte keeps the input side closed in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted in two consecutive cycles");

    // When the final word of a byte is taken while no byte is in progress, the output goes quiet.
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_of_item && !in_stall) |=> !out_valid)
        else $error("output word after the final word of a byte");

    // The closing character of digest one is always followed by that of digest two.
    a_close_one_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_closing && !which_digest) |-> !last_of_item)
        else $error("closing character of digest one marked as final");

    // A register write lands only while no byte is being processed.
    a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> !in_stall)
        else $error("configuration written while a byte is in progress");

endmodule

// ----- rtl/ctph_mod_unit.sv -----
// Iterative restoring divider giving the remainder and the lowest quotient bit.
module ctph_mod_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ctph_pkg::HASH_W-1:0]          dividend,
    input  logic [ctph_pkg::BLOCK_SIZE_W-1:0]    divisor,
    output logic                                 done,
    output logic [ctph_pkg::BLOCK_SIZE_W-1:0]    remainder,
    output logic                                 quot_lsb
);
    import ctph_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [HASH_W-1:0]       shift_reg;
    logic [BLOCK_SIZE_W-1:0] rem_reg;
    logic                    qbit_reg;

    logic [HASH_W-1:0]       trial;
    logic                    ge;
    logic [HASH_W-1:0]       diff;
    logic [BLOCK_SIZE_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, shift_reg[HASH_W-1]};
        ge       = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[BLOCK_SIZE_W-1:0] : trial[BLOCK_SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(HASH_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            qbit_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[HASH_W-2:0], 1'b0};
            rem_reg   <= rem_next;
            qbit_reg  <= ge;
        end
    end

    assign done      = busy_reg && (cnt_reg == CNT_W'(HASH_W - 1));
    assign remainder = rem_reg;
    assign quot_lsb  = qbit_reg;

endmodule

// ----- rtl/ctph_datapath.sv -----
// Rolling hash, piece hashes, trigger evaluation and output word register.
module ctph_datapath #(
    parameter int ROLL_WINDOW = ctph_pkg::ROLL_WINDOW_DEF,
    parameter int DIGEST_LEN  = ctph_pkg::DIGEST_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ctph_pkg::ctph_cmd_t                 cmd,
    output ctph_pkg::ctph_status_t              sts,
    input  logic                                cfg_write,
    input  logic [ctph_pkg::BLOCK_SIZE_W-1:0]   cfg_block_size,
    input  logic [ctph_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                end_of_message,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ctph_pkg::CHAR_W-1:0]         digest_char,
    output logic                                which_digest,
    output logic                                is_closing,
    output logic                                last_of_item
);
    import ctph_pkg::*;

    localparam int POS_W  = $clog2(ROLL_WINDOW);
    localparam int CNT1_W = $clog2(DIGEST_LEN);
    localparam int CNT2_W = $clog2(DIGEST_LEN / 2);

    logic [BLOCK_SIZE_W-1:0] block_size_reg;
    logic [BYTE_W-1:0]       byte_reg;
    logic                    eom_reg;
    logic [BYTE_W-1:0]       window_reg [ROLL_WINDOW];
    logic [POS_W-1:0]        pos_reg;
    logic [HASH_W-1:0]       roll_sum_reg;
    logic [HASH_W-1:0]       roll_weighted_reg;
    logic [HASH_W-1:0]       roll_shift_reg;
    logic [HASH_W-1:0]       roll_value_reg;
    logic [HASH_W-1:0]       piece_one_reg;
    logic [HASH_W-1:0]       piece_two_reg;
    logic [CNT1_W-1:0]       count_one_reg;
    logic [CNT2_W-1:0]       count_two_reg;
    logic                    trig_one_reg;
    logic                    trig_two_reg;
    logic                    out_valid_reg;
    logic [CHAR_W-1:0]       char_reg;
    logic                    which_reg;
    logic                    closing_reg;
    logic                    last_reg;

    logic [HASH_W-1:0]       byte_ext;
    logic [HASH_W-1:0]       roll_sum_next;
    logic [HASH_W-1:0]       roll_weighted_next;
    logic [HASH_W-1:0]       roll_shift_next;
    logic [POS_W-1:0]        pos_next;
    logic                    mod_done;
    logic [BLOCK_SIZE_W-1:0] mod_rem;
    logic                    mod_qlsb;
    logic                    rem_match;
    logic [HASH_W-1:0]       emit_hash;
    logic                    emit_last;

    ctph_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (roll_value_reg),
        .divisor   (block_size_reg),
        .done      (mod_done),
        .remainder (mod_rem),
        .quot_lsb  (mod_qlsb)
    );

    always_comb
    begin
        byte_ext           = {{(HASH_W - BYTE_W){1'b0}}, byte_reg};
        roll_weighted_next = roll_weighted_reg - roll_sum_reg
                             + (HASH_W'(ROLL_WINDOW) * byte_ext);
        roll_sum_next      = roll_sum_reg + byte_ext
                             - {{(HASH_W - BYTE_W){1'b0}}, window_reg[pos_reg]};
        roll_shift_next    = {roll_shift_reg[HASH_W-6:0], 5'b0} ^ byte_ext;
        pos_next           = (pos_reg == POS_W'(ROLL_WINDOW - 1)) ? '0 : pos_reg + 1'b1;
        rem_match          = (block_size_reg != '0) && (mod_rem == block_size_reg - 1'b1);
    end

    always_comb
    begin
        emit_hash = piece_one_reg;
        emit_last = 1'b0;
        unique case (cmd.sel)
            EMIT_PIECE_ONE:
            begin
                emit_hash = piece_one_reg;
                emit_last = !trig_two_reg && !eom_reg;
            end
            EMIT_PIECE_TWO:
            begin
                emit_hash = piece_two_reg;
                emit_last = !eom_reg;
            end
            EMIT_CLOSE_ONE:
            begin
                emit_hash = piece_one_reg;
                emit_last = 1'b0;
            end
            EMIT_CLOSE_TWO:
            begin
                emit_hash = piece_two_reg;
                emit_last = 1'b1;
            end
            default:
            begin
                emit_hash = piece_one_reg;
                emit_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RST;
        end
        else if (cfg_write)
        begin
            block_size_reg <= cfg_block_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= data_byte;
            eom_reg  <= end_of_message;
        end
        if (cmd.update)
        begin
            roll_value_reg <= roll_sum_next + roll_weighted_next + roll_shift_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROLL_WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
            pos_reg           <= '0;
            roll_sum_reg      <= '0;
            roll_weighted_reg <= '0;
            roll_shift_reg    <= '0;
            piece_one_reg     <= PIECE_INIT;
            piece_two_reg     <= PIECE_INIT;
            count_one_reg     <= '0;
            count_two_reg     <= '0;
            trig_one_reg      <= 1'b0;
            trig_two_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < ROLL_WINDOW; i++)
                begin
                    window_reg[i] <= '0;
                end
                pos_reg           <= '0;
                roll_sum_reg      <= '0;
                roll_weighted_reg <= '0;
                roll_shift_reg    <= '0;
                piece_one_reg     <= PIECE_INIT;
                piece_two_reg     <= PIECE_INIT;
                count_one_reg     <= '0;
                count_two_reg     <= '0;
            end
            else if (cmd.update)
            begin
                window_reg[pos_reg] <= byte_reg;
                pos_reg             <= pos_next;
                roll_sum_reg        <= roll_sum_next;
                roll_weighted_reg   <= roll_weighted_next;
                roll_shift_reg      <= roll_shift_next;
                piece_one_reg       <= (piece_one_reg * FNV_PRIME) ^ byte_ext;
                piece_two_reg       <= (piece_two_reg * FNV_PRIME) ^ byte_ext;
            end
            else if (cmd.emit && (cmd.sel == EMIT_PIECE_ONE))
            begin
                piece_one_reg <= PIECE_INIT;
                count_one_reg <= count_one_reg + 1'b1;
            end
            else if (cmd.emit && (cmd.sel == EMIT_PIECE_TWO))
            begin
                piece_two_reg <= PIECE_INIT;
                count_two_reg <= count_two_reg + 1'b1;
            end

            if (cmd.capture)
            begin
                trig_one_reg <= rem_match && (count_one_reg < CNT1_W'(DIGEST_LEN - 1));
                trig_two_reg <= rem_match && mod_qlsb
                                && (count_two_reg < CNT2_W'(DIGEST_LEN / 2 - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg    <= b64_char(emit_hash[5:0]);
            which_reg   <= (cmd.sel == EMIT_PIECE_TWO) || (cmd.sel == EMIT_CLOSE_TWO);
            closing_reg <= (cmd.sel == EMIT_CLOSE_ONE) || (cmd.sel == EMIT_CLOSE_TWO);
            last_reg    <= emit_last;
        end
    end

    assign sts.mod_done  = mod_done;
    assign sts.trig_one  = trig_one_reg;
    assign sts.trig_two  = trig_two_reg;
    assign sts.eom       = eom_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign digest_char  = char_reg;
    assign which_digest = which_reg;
    assign is_closing   = closing_reg;
    assign last_of_item = last_reg;

endmodule

// ----- rtl/ctph_ctrl.sv -----
// Controller state machine sequencing one byte through update, modulo and emission.
module ctph_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  ctph_pkg::ctph_status_t  sts,
    output ctph_pkg::ctph_cmd_t     cmd,
    output logic                    idle
);
    import ctph_pkg::*;

    ctph_state_t state_reg;
    ctph_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = EMIT_PIECE_ONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.capture = 1'b1;
                state_next  = S_EMIT_ONE;
            end
            S_EMIT_ONE:
            begin
                cmd.sel = EMIT_PIECE_ONE;
                if (!sts.trig_one)
                begin
                    state_next = S_EMIT_TWO;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_EMIT_TWO;
                end
            end
            S_EMIT_TWO:
            begin
                cmd.sel = EMIT_PIECE_TWO;
                if (!sts.trig_two || sts.out_free)
                begin
                    cmd.emit   = sts.trig_two;
                    state_next = sts.eom ? S_CLOSE_ONE : S_IDLE;
                end
            end
            S_CLOSE_ONE:
            begin
                cmd.sel = EMIT_CLOSE_ONE;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CLOSE_TWO;
                end
            end
            S_CLOSE_TWO:
            begin
                cmd.sel = EMIT_CLOSE_TWO;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

endmodule

// ----- dv/ctph_digest_checker.sv -----
// Checker that predicts each digest word of the piecewise digest unit and compares it.
module ctph_digest_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [ctph_pkg::BLOCK_SIZE_W-1:0] block_size,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [ctph_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              end_of_message,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [ctph_pkg::CHAR_W-1:0]       digest_char,
    input  logic                              which_digest,
    input  logic                              is_closing,
    input  logic                              last_of_item,
    output int                                mismatches,
    output int                                chars_pending,
    output int                                bytes_seen,
    output int                                triggers_seen,
    output int                                closings_seen
);
    import ctph_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              which;
        logic              closing;
        logic              last;
    } digest_word_t;

    string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic [BYTE_W-1:0]       window [ROLL_WINDOW_DEF];
    logic [2:0]              window_idx;
    logic [HASH_W-1:0]       sum_acc;
    logic [HASH_W-1:0]       weight_acc;
    logic [HASH_W-1:0]       shift_acc;
    logic [HASH_W-1:0]       piece_one;
    logic [HASH_W-1:0]       piece_two;
    logic [5:0]              filled_one;
    logic [4:0]              filled_two;
    logic [BLOCK_SIZE_W-1:0] modulus;
    digest_word_t            expected_chars [$];
    int                      mism_count = 0;
    int                      byte_count = 0;
    int                      trigger_count = 0;
    int                      closing_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        mism_count++;
        $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic clear_message_state();
        foreach (window[i])
        begin
            window[i] = '0;
        end
        window_idx = '0;
        sum_acc    = '0;
        weight_acc = '0;
        shift_acc  = '0;
        piece_one  = PIECE_INIT;
        piece_two  = PIECE_INIT;
        filled_one = '0;
        filled_two = '0;
    endtask

    task automatic queue_char(input logic [HASH_W-1:0] hash, input logic which,
                              input logic closing);
        digest_word_t w;
        byte          b;
        b         = b64_alphabet.getc(int'(hash[5:0]));
        w.ch      = b[CHAR_W-1:0];
        w.which   = which;
        w.closing = closing;
        w.last    = 1'b0;
        expected_chars.insert(expected_chars.size(), w);
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] c, input logic eom);
        logic [HASH_W-1:0] cw;
        logic [HASH_W-1:0] roll;
        logic [HASH_W-1:0] m1;
        logic [HASH_W-1:0] m2;
        int                first;
        first      = expected_chars.size();
        cw         = {24'd0, c};
        piece_one  = (piece_one * FNV_PRIME) ^ cw;
        piece_two  = (piece_two * FNV_PRIME) ^ cw;
        weight_acc = weight_acc - sum_acc + ROLL_WINDOW_DEF * cw;
        sum_acc    = sum_acc + cw - {24'd0, window[window_idx]};
        window[window_idx] = c;
        window_idx = (window_idx == 3'(ROLL_WINDOW_DEF - 1)) ? 3'd0 : window_idx + 3'd1;
        shift_acc  = (shift_acc << 5) ^ cw;
        roll       = sum_acc + weight_acc + shift_acc;
        if (modulus != '0)
        begin
            m1 = {1'b0, modulus};
            m2 = m1 << 1;
            if (roll % m1 == m1 - 32'd1 && filled_one < 6'(DIGEST_LEN_DEF - 1))
            begin
                queue_char(piece_one, 1'b0, 1'b0);
                piece_one  = PIECE_INIT;
                filled_one = filled_one + 6'd1;
            end
            if (roll % m2 == m2 - 32'd1 && filled_two < 5'(DIGEST_LEN_DEF / 2 - 1))
            begin
                queue_char(piece_two, 1'b1, 1'b0);
                piece_two  = PIECE_INIT;
                filled_two = filled_two + 5'd1;
            end
        end
        if (eom)
        begin
            queue_char(piece_one, 1'b0, 1'b1);
            queue_char(piece_two, 1'b1, 1'b1);
            clear_message_state();
        end
        if (expected_chars.size() > first)
        begin
            expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t want;
        if (!rst_n)
        begin
            modulus = BLOCK_SIZE_RST;
            clear_message_state();
            expected_chars.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                modulus = block_size;
            end
            if (in_valid && !in_stall)
            begin
                absorb_byte(data_byte, end_of_message);
                byte_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (is_closing)
                begin
                    closing_count++;
                end
                else
                begin
                    trigger_count++;
                end
                if (expected_chars.size() == 0)
                begin
                    report_mismatch("unexpected word, digest_char", digest_char, -1);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (digest_char !== want.ch)
                    begin
                        report_mismatch("digest_char", digest_char, want.ch);
                    end
                    if (which_digest !== want.which)
                    begin
                        report_mismatch("which_digest", which_digest, want.which);
                    end
                    if (is_closing !== want.closing)
                    begin
                        report_mismatch("is_closing", is_closing, want.closing);
                    end
                    if (last_of_item !== want.last)
                    begin
                        report_mismatch("last_of_item", last_of_item, want.last);
                    end
                end
            end
        end
        mismatches    <= mism_count;
        chars_pending <= expected_chars.size();
        bytes_seen    <= byte_count;
        triggers_seen <= trigger_count;
        closings_seen <= closing_count;
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the piecewise digest unit: clock, reset, stimulus and the final verdict.
module tb_top;

    localparam int QUIET_LIMIT = 4000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ctph_pkg::BLOCK_SIZE_W-1:0] block_size = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [ctph_pkg::BYTE_W-1:0]       data_byte = '0;
    logic                              end_of_message = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [ctph_pkg::CHAR_W-1:0]       digest_char;
    logic                              which_digest;
    logic                              is_closing;
    logic                              last_of_item;

    int mismatches;
    int chars_pending;
    int bytes_seen;
    int triggers_seen;
    int closings_seen;
    int send_idle = 30;
    int recv_idle = 77;
    int sizes_used = 0;
    int quiet_cycles = 0;

    ctph_piecewise_digest_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .block_size     (block_size),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_char    (digest_char),
        .which_digest   (which_digest),
        .is_closing     (is_closing),
        .last_of_item   (last_of_item)
    );

    ctph_digest_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .block_size     (block_size),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_char    (digest_char),
        .which_digest   (which_digest),
        .is_closing     (is_closing),
        .last_of_item   (last_of_item),
        .mismatches     (mismatches),
        .chars_pending  (chars_pending),
        .bytes_seen     (bytes_seen),
        .triggers_seen  (triggers_seen),
        .closings_seen  (closings_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic settle(input int tail);
        @(posedge clk);
        while (chars_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_block_size(input logic [ctph_pkg::BLOCK_SIZE_W-1:0] value);
        in_valid <= 1'b0;
        settle(45);
        cfg_valid  <= 1'b1;
        block_size <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sizes_used++;
    endtask

    task automatic run_messages(input logic [ctph_pkg::BLOCK_SIZE_W-1:0] size,
                                input int total, input int max_len);
        int left;
        int len;
        write_block_size(size);
        left = total;
        while (left > 0)
        begin
            len = $urandom_range(1, max_len);
            if (len > left)
            begin
                len = left;
            end
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
            left -= len;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hFF, 1'b1);
        // With a block size of one every byte triggers digest one, so its closing word follows a restart.
        write_block_size(31'd1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h10, 1'b1);
        write_block_size(31'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3C, 1'b1);
        write_block_size(31'd2);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_block_size(31'h7FFF_FFFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        write_block_size(31'h6000_0000);
        send_byte(8'hA5, 1'b1);

        // A long message at block size one runs both digests into their full state.
        write_block_size(31'd1);
        for (int i = 0; i < 90; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), i == 89);
        end
        run_messages(31'd3, 20, 12);

        send_idle = 77;
        recv_idle = 30;
        run_messages(31'($urandom_range(4, 64)), 25, 16);
        run_messages(31'd2, 15, 8);
        run_messages(31'h6000_0000, 8, 8);

        send_idle = 0;
        recv_idle = 0;
        run_messages(31'd5, 25, 16);
        run_messages(31'd1, 12, 6);
        run_messages(31'd3, 10, 16);

        in_valid <= 1'b0;
        settle(60);
        $display("Sent %0d bytes over %0d block sizes, zero, one and the widest among them.",
                 bytes_seen, sizes_used);
        $display("Checked %0d trigger and %0d closing characters.", triggers_seen, closings_seen);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ctph_pkg.sv
rtl/ctph_mod_unit.sv
rtl/ctph_datapath.sv
rtl/ctph_ctrl.sv
rtl/ctph_piecewise_digest_unit.sv
dv/ctph_digest_checker.sv
dv/tb_top.sv
